FILE: sv/tiff_strip_sample_packer_assert.svh
// Assertion macros used by the checker file tsp_checker.sv.
`ifndef TIFF_STRIP_SAMPLE_PACKER_ASSERT_SVH
`define TIFF_STRIP_SAMPLE_PACKER_ASSERT_SVH

// Checked only while the block is out of reset.
`define TSP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tsp assertion failed");

// Checked at every edge, reset included.
`define TSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tsp assertion failed");

`endif

FILE: sv/tsp_pkg.sv
package tsp_pkg;

  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_BPS_CODE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPP        = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RPS        = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_LITTLE_END = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_ODD  = 3'd6;

  localparam logic [2:0] BPS_1  = 3'd0;
  localparam logic [2:0] BPS_2  = 3'd1;
  localparam logic [2:0] BPS_4  = 3'd2;
  localparam logic [2:0] BPS_8  = 3'd3;
  localparam logic [2:0] BPS_16 = 3'd4;

  localparam int MAX_BYTES = 3;
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = 2;

  typedef struct packed {
    logic [1:0]                cnt;
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic                      pad;
    logic                      done;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } q_head_t;

endpackage

FILE: sv/tsp_queue.sv
module tsp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tsp_pkg::group_t push_grp,
  output logic            full,
  input  logic            pop,
  output tsp_pkg::q_head_t head
);
  import tsp_pkg::*;

  group_t                mem_r [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]    count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full    = (count_r == (QPTR_BITS+1)'(QDEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.grp   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

endmodule

FILE: sv/tsp_front.sv
module tsp_front #(
  parameter int DIM_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tsp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [DIM_BITS-1:0]               cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,
  input  logic                              q_full,
  output logic                              push,
  output tsp_pkg::group_t                   push_grp
);
  import tsp_pkg::*;

  logic [2:0]          bps_r, spp_r;
  logic [DIM_BITS-1:0] width_r, height_r, rps_r;
  logic                le_r;

  logic [7:0]          acc_r, acc_nxt;
  logic [2:0]          bf_r, bf_nxt;
  logic [7:0]          high_r;
  logic                phase_r, phase_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;
  logic [1:0]          sip_r, sip_nxt;
  logic [DIM_BITS-1:0] ris_r, ris_nxt;
  logic [DIM_BITS-1:0] rows_r, rows_nxt;
  logic                parity_r, parity_nxt;
  logic                done_r, done_nxt;

  logic                go, packed_mode, is16, phase, complete, pad;
  logic [3:0]          pbits, sh;
  logic [2:0]          spp_eff;
  logic [DIM_BITS-1:0] w_eff, h_eff, rps_eff, rows_inc;
  logic [DIM_BITS:0]   col_inc, ris_inc;
  logic                sip_last, col_last, row_end;
  logic                flush1, flush2;
  logic [7:0]          acc0, acc1, top8, d0, d1;
  logic [2:0]          bf0;
  logic [3:0]          nb;
  logic [1:0]          dn, n;

  assign in_tready = ~q_full;
  assign go        = in_tvalid & in_tready & ~done_r;

  always_comb begin
    packed_mode = (bps_r <= BPS_4);
    is16        = (bps_r == BPS_16);
    phase       = is16 & phase_r;
    case (bps_r)
      BPS_1:   pbits = 4'd1;
      BPS_2:   pbits = 4'd2;
      BPS_4:   pbits = 4'd4;
      default: pbits = 4'd0;
    endcase
    if (packed_mode || spp_r == 3'd0) begin
      spp_eff = 3'd1;
    end else if (spp_r > 3'd4) begin
      spp_eff = 3'd4;
    end else begin
      spp_eff = spp_r;
    end
    w_eff   = width_r  | {{(DIM_BITS-1){1'b0}}, (width_r == '0)};
    h_eff   = height_r | {{(DIM_BITS-1){1'b0}}, (height_r == '0)};
    rps_eff = rps_r    | {{(DIM_BITS-1){1'b0}}, (rps_r == '0)};

    pad      = parity_r & (ris_r == '0) & (col_r == '0) & (sip_r == '0) & ~phase;
    complete = ~(is16 & ~phase);

    sip_last = (({1'b0, sip_r} + 3'd1) >= spp_eff);
    col_inc  = {1'b0, col_r} + 1'b1;
    col_last = (col_inc >= {1'b0, w_eff});
    row_end  = complete & sip_last & col_last;
    ris_inc  = {1'b0, ris_r} + 1'b1;
    rows_inc = rows_r + 1'b1;

    flush1 = (({1'b0, bf_r} + pbits) > 4'd8);
    acc0   = flush1 ? 8'd0 : acc_r;
    bf0    = flush1 ? 3'd0 : bf_r;
    case (bps_r)
      BPS_1:   top8 = {7'd0, in_tdata[7]};
      BPS_2:   top8 = {6'd0, in_tdata[7:6]};
      default: top8 = {4'd0, in_tdata[7:4]};
    endcase
    sh     = 4'd8 - {1'b0, bf0} - pbits;
    acc1   = acc0 | (top8 << sh[2:0]);
    nb     = {1'b0, bf0} + pbits;
    flush2 = (nb >= 4'd8) | row_end;

    d0 = in_tdata;
    d1 = in_tdata;
    dn = 2'd0;
    if (complete) begin
      if (packed_mode) begin
        if (flush1) begin
          d0 = acc_r;
          d1 = acc1;
          dn = flush2 ? 2'd2 : 2'd1;
        end else begin
          d0 = acc1;
          dn = flush2 ? 2'd1 : 2'd0;
        end
      end else if (is16) begin
        d0 = le_r ? in_tdata : high_r;
        d1 = le_r ? high_r : in_tdata;
        dn = 2'd2;
      end else begin
        dn = 2'd1;
      end
    end
    n = dn + {1'b0, pad};

    acc_nxt    = acc_r;
    bf_nxt     = bf_r;
    phase_nxt  = phase_r;
    col_nxt    = col_r;
    sip_nxt    = sip_r;
    ris_nxt    = ris_r;
    rows_nxt   = rows_r;
    done_nxt   = done_r;
    parity_nxt = parity_r;
    if (go) begin
      phase_nxt  = is16 & ~phase;
      parity_nxt = parity_r ^ n[0];
      if (complete) begin
        if (sip_last) begin
          sip_nxt = 2'd0;
          col_nxt = col_last ? '0 : col_inc[DIM_BITS-1:0];
        end else begin
          sip_nxt = sip_r + 1'b1;
        end
        if (packed_mode) begin
          acc_nxt = flush2 ? 8'd0 : acc1;
          bf_nxt  = flush2 ? 3'd0 : nb[2:0];
        end
        if (row_end) begin
          rows_nxt = rows_inc;
          ris_nxt  = (ris_inc >= {1'b0, rps_eff}) ? '0 : ris_inc[DIM_BITS-1:0];
          if (rows_inc >= h_eff) begin
            done_nxt = 1'b1;
          end
        end
      end
    end
    if (cfg_we && cfg_index == REG_START_ODD) begin
      parity_nxt = cfg_wdata[0];
    end
  end

  assign push          = go & (n != 2'd0);
  assign push_grp.cnt  = n;
  assign push_grp.pad  = pad;
  assign push_grp.done = done_nxt;
  assign push_grp.bytes[0] = pad ? 8'd0 : d0;
  assign push_grp.bytes[1] = pad ? d0 : d1;
  assign push_grp.bytes[2] = d1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r    <= BPS_8;
      spp_r    <= 3'd1;
      width_r  <= DIM_BITS'(1);
      height_r <= DIM_BITS'(1);
      rps_r    <= DIM_BITS'(1);
      le_r     <= 1'b0;
      acc_r    <= '0;
      bf_r     <= '0;
      high_r   <= '0;
      phase_r  <= 1'b0;
      col_r    <= '0;
      sip_r    <= '0;
      ris_r    <= '0;
      rows_r   <= '0;
      parity_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      bf_r     <= bf_nxt;
      phase_r  <= phase_nxt;
      col_r    <= col_nxt;
      sip_r    <= sip_nxt;
      ris_r    <= ris_nxt;
      rows_r   <= rows_nxt;
      done_r   <= done_nxt;
      parity_r <= parity_nxt;
      if (go && is16 && !phase) begin
        high_r <= in_tdata;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BPS_CODE:   bps_r    <= cfg_wdata[2:0];
          REG_SPP:        spp_r    <= cfg_wdata[2:0];
          REG_WIDTH:      width_r  <= cfg_wdata;
          REG_HEIGHT:     height_r <= cfg_wdata;
          REG_RPS:        rps_r    <= cfg_wdata;
          REG_LITTLE_END: le_r     <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: sv/tsp_back.sv
module tsp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tsp_pkg::q_head_t head,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  output logic [1:0]       out_tuser
);
  import tsp_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       last, take;

  assign out_tvalid = head.valid;
  assign last       = (idx_r == head.grp.cnt - 2'd1);
  assign take       = out_tvalid & out_tready;
  assign pop        = take & last;

  always_comb begin
    case (idx_r)
      2'd0:    out_tdata = head.grp.bytes[0];
      2'd1:    out_tdata = head.grp.bytes[1];
      default: out_tdata = head.grp.bytes[2];
    endcase
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  assign out_tlast    = last;
  assign out_tuser[0] = head.grp.pad & (idx_r == 2'd0);
  assign out_tuser[1] = head.grp.done & last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

FILE: sv/tiff_strip_sample_packer.sv
// Channel   Direction  tdata        tuser                    tlast
// in_       slave      sample_byte  -                        -
// out_      master     out_byte     is_pad, image_done       last_of_run
// cfg_      write      data         -                        -
//
// An item is classified and its up to three result bytes are formed combinationally when it is taken.
// A new item is taken every cycle while the four-entry group queue has room.
// The output port drains one byte per cycle while out_tready is high, so the sustained rate equals the bytes made.
// Items that make two or three bytes hold back the input once the queue fills.
// Synchronous active-low reset; no clearing pass is needed.
module tiff_strip_sample_packer #(
  parameter int DIM_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tsp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [DIM_BITS-1:0]               cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] sample_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [7:0] out_byte
  output logic                              out_tlast,
  output logic [1:0]                        out_tuser   // [0] is_pad, [1] image_done
);
  import tsp_pkg::*;

  logic    q_full, push, pop;
  group_t  push_grp;
  q_head_t head;

  tsp_front #(
    .DIM_BITS(DIM_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_grp  (push_grp)
  );

  tsp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  tsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: sv/tsp_checker.sv
`include "tiff_strip_sample_packer_assert.svh"

module tsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [1:0] out_tuser
);

  `TSP_ASSERT(a_hold_valid, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `TSP_ASSERT(a_done_last, clk, rst_n, out_tvalid && out_tuser[1] |-> out_tlast)
  `TSP_ASSERT(a_pad_zero, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tdata == 8'd0)
  `TSP_ASSERT(a_quiet_after, clk, rst_n, out_tvalid && out_tready && out_tuser[1] |=> !out_tvalid)
  `TSP_ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> !out_tvalid && in_tready)

endmodule

bind tiff_strip_sample_packer tsp_checker u_tsp_checker (.*);

FILE: tb/sv/tb.sv
module tb;
  import tsp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       pad;
    logic       last;
    logic       done;
  } out_byte_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_SAMPLE_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [15:0]             value;
    out_byte_t               known;
  } stim_row_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_THIRD, RX_BLOCKS} rx_mode_e;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 170;
  localparam int N_DIRECTED    = 50;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [15:0]             cfg_wdata = '0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [7:0]              in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [7:0]              out_tdata;
  logic                    out_tlast;
  logic [1:0]              out_tuser;

  tiff_strip_sample_packer dut (.*);

  always #1 clk = ~clk;

  // Packer state as seen by the predictor.
  logic [2:0]  m_bps, m_spp;
  logic [15:0] m_width, m_height, m_rps;
  logic        m_le, m_start_odd;
  logic [7:0]  acc, hi_hold;
  logic [2:0]  nbits;
  logic        phase, parity, img_done;
  logic [15:0] col, strip_row, rows_done;
  logic [1:0]  samp;

  out_byte_t step_bytes[$];
  out_byte_t expected_bytes[$];

  logic      use_known = 1'b0;
  out_byte_t known_byte = '0;
  int        burst_left = 0;
  int        byte_errors = 0;
  int        bytes_seen = 0;

  function automatic void reset_packer();
    m_bps = BPS_8; m_spp = 3'd1; m_width = 16'd1; m_height = 16'd1; m_rps = 16'd1;
    m_le = 1'b0; m_start_odd = 1'b0;
    acc = '0; nbits = '0; hi_hold = '0; phase = 1'b0;
    col = '0; samp = '0; strip_row = '0; rows_done = '0;
    parity = 1'b0; img_done = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] v);
    case (idx)
      REG_BPS_CODE:   m_bps = v[2:0];
      REG_SPP:        m_spp = v[2:0];
      REG_WIDTH:      m_width = v;
      REG_HEIGHT:     m_height = v;
      REG_RPS:        m_rps = v;
      REG_LITTLE_END: m_le = v[0];
      REG_START_ODD: begin
        m_start_odd = v[0];
        parity = v[0];
      end
      default: ;
    endcase
  endfunction

  function automatic void push_byte(logic [7:0] b, logic pad);
    step_bytes.push_back('{b, pad, 1'b0, 1'b0});
    parity = ~parity;
  endfunction

  function automatic void pack_sample(logic [7:0] s);
    int unsigned bits_per, spp, w, h, rps, nb;
    logic        complete, row_end;
    step_bytes.delete();
    if (img_done) return;
    bits_per = (m_bps <= BPS_4) ? (32'd1 << m_bps) : 32'd0;
    if (m_bps != BPS_16) phase = 1'b0;
    spp = (m_spp == 3'd0) ? 1 : ((m_spp > 3'd4) ? 4 : m_spp);
    if (bits_per != 0) spp = 1;
    w = (m_width == 16'd0) ? 1 : m_width;
    h = (m_height == 16'd0) ? 1 : m_height;
    rps = (m_rps == 16'd0) ? 1 : m_rps;
    complete = 1'b1;
    row_end = 1'b0;
    if (strip_row == 0 && col == 0 && samp == 0 && !phase && parity) push_byte(8'h00, 1'b1);
    if (m_bps == BPS_16 && !phase) begin
      hi_hold = s;
      phase = 1'b1;
      complete = 1'b0;
    end
    if (complete) begin
      if (samp + 32'd1 >= spp) begin
        samp = '0;
        if (col + 32'd1 >= w) begin
          row_end = 1'b1;
          col = '0;
        end else begin
          col = col + 16'd1;
        end
      end else begin
        samp = samp + 2'd1;
      end
      if (bits_per != 0) begin
        if (nbits + bits_per > 8) begin
          push_byte(acc, 1'b0);
          acc = '0;
          nbits = '0;
        end
        acc = acc | 8'((32'(s) >> (8 - bits_per)) << (8 - nbits - bits_per));
        nb = nbits + bits_per;
        if (nb >= 8 || row_end) begin
          push_byte(acc, 1'b0);
          acc = '0;
          nbits = '0;
        end else begin
          nbits = 3'(nb);
        end
      end else if (m_bps == BPS_16) begin
        phase = 1'b0;
        if (m_le) begin
          push_byte(s, 1'b0);
          push_byte(hi_hold, 1'b0);
        end else begin
          push_byte(hi_hold, 1'b0);
          push_byte(s, 1'b0);
        end
      end else begin
        push_byte(s, 1'b0);
      end
      if (row_end) begin
        rows_done = rows_done + 16'd1;
        if (strip_row + 32'd1 >= rps) strip_row = '0;
        else strip_row = strip_row + 16'd1;
        if (rows_done >= h) img_done = 1'b1;
      end
    end
    if (step_bytes.size() != 0) begin
      step_bytes[step_bytes.size()-1].last = 1'b1;
      if (img_done) step_bytes[step_bytes.size()-1].done = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : byte_check
    out_byte_t got, want;
    if (rst_n) begin
      if (cfg_we) apply_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) begin
        pack_sample(in_tdata);
        if (use_known) expected_bytes.push_back(known_byte);
        else foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata, out_tuser[0], out_tlast, out_tuser[1]};
        if (expected_bytes.size() == 0) begin
          byte_errors++;
          if (byte_errors <= 10)
            $display("byte %0d unexpected: data %h pad %b last %b done %b",
                     bytes_seen, got.data, got.pad, got.last, got.done);
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            byte_errors++;
            if (byte_errors <= 10)
              $display("byte %0d: expected data %h pad %b last %b done %b, got %h %b %b %b",
                       bytes_seen, want.data, want.pad, want.last, want.done,
                       got.data, got.pad, got.last, got.done);
          end
        end
        bytes_seen++;
      end
    end
  end

  int       rx_cycle = 0;
  int       rx_hold = 0;
  rx_mode_e rx_mode = RX_FREE;

  always @(negedge clk) begin : receiver
    logic rdy;
    rx_cycle++;
    if (rx_cycle % 60 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:  rdy = 1'b1;
      RX_COIN:  rdy = 1'($urandom_range(0, 1));
      RX_THIRD: rdy = (rx_cycle % 3 == 0);
      default: begin
        if (rx_hold == 0 && $urandom_range(0, 15) == 0) rx_hold = $urandom_range(5, 20);
        rdy = (rx_hold == 0);
        if (rx_hold != 0) rx_hold--;
      end
    endcase
    out_tready <= rdy;
  end

  // Called and returning at a falling edge.
  task automatic send_sample(input logic [7:0] s, input logic known, input out_byte_t kb);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= s;
    use_known <= known;
    known_byte <= kb;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(inout int sent);
    int unsigned spp_eff, w_eff, per_row, n;
    wait_idle();
    if ($urandom_range(0, 9) < 6)
      write_reg(REG_BPS_CODE, 16'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
                                                              : $urandom_range(0, 4)));
    if ($urandom_range(0, 1))
      write_reg(REG_SPP, 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                         : $urandom_range(1, 4)));
    if ($urandom_range(0, 1))
      case ($urandom_range(0, 9))
        0: write_reg(REG_WIDTH, 16'd0);
        1: write_reg(REG_WIDTH, 16'hFFFF);
        default: write_reg(REG_WIDTH, 16'($urandom_range(1, 12)));
      endcase
    if ($urandom_range(0, 2) == 0)
      case ($urandom_range(0, 5))
        0: write_reg(REG_RPS, 16'd0);
        1: write_reg(REG_RPS, 16'hFFFF);
        default: write_reg(REG_RPS, 16'($urandom_range(1, 4)));
      endcase
    if ($urandom_range(0, 1)) write_reg(REG_LITTLE_END, 16'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) write_reg(REG_START_ODD, 16'($urandom_range(0, 1)));
    if ($urandom_range(0, 7) == 0) write_reg(REG_HEIGHT, 16'($urandom_range(40000, 65535)));

    spp_eff = (m_spp == 3'd0) ? 1 : ((m_spp > 3'd4) ? 4 : m_spp);
    if (m_bps <= BPS_4) spp_eff = 1;
    w_eff = (m_width == 16'd0) ? 1 : m_width;
    per_row = w_eff * spp_eff * ((m_bps == BPS_16) ? 2 : 1);
    if (per_row > 40) n = $urandom_range(3, 12);
    else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 20);
    else n = per_row * $urandom_range(1, 40 / per_row);

    repeat (n) begin
      if ($urandom_range(0, 40) == 0) wait_idle();
      send_sample(8'($urandom_range(0, 255)), 1'b0, '0);
    end
    sent += n;
  endtask

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_CFG, REG_HEIGHT, 16'hFFFF, '0},
    '{ROW_CFG, REG_RPS, 16'd2, '0},
    '{ROW_CFG, REG_WIDTH, 16'd2, '0},
    '{ROW_CFG, REG_START_ODD, 16'd1, '0},
    '{ROW_CFG, REG_BPS_CODE, 16'(BPS_8), '0},
    '{ROW_SAMPLE, '0, 16'h00, '0},
    '{ROW_SAMPLE_KNOWN, '0, 16'hFF, '{8'hFF, 1'b0, 1'b1, 1'b0}},
    '{ROW_SAMPLE_KNOWN, '0, 16'h01, '{8'h01, 1'b0, 1'b1, 1'b0}},
    '{ROW_SAMPLE_KNOWN, '0, 16'h80, '{8'h80, 1'b0, 1'b1, 1'b0}},
    '{ROW_CFG, REG_BPS_CODE, 16'(BPS_1), '0},
    '{ROW_CFG, REG_WIDTH, 16'd3, '0},
    '{ROW_CFG, REG_RPS, 16'd1, '0},
    '{ROW_SAMPLE, '0, 16'hFF, '0},
    '{ROW_SAMPLE, '0, 16'h7F, '0},
    '{ROW_SAMPLE_KNOWN, '0, 16'h80, '{8'hA0, 1'b0, 1'b1, 1'b0}},
    '{ROW_CFG, REG_BPS_CODE, 16'(BPS_2), '0},
    '{ROW_CFG, REG_WIDTH, 16'd5, '0},
    '{ROW_SAMPLE, '0, 16'hC0, '0},
    '{ROW_SAMPLE, '0, 16'h40, '0},
    '{ROW_SAMPLE, '0, 16'h80, '0},
    '{ROW_SAMPLE_KNOWN, '0, 16'h3F, '{8'hD8, 1'b0, 1'b1, 1'b0}},
    '{ROW_SAMPLE_KNOWN, '0, 16'hFF, '{8'hC0, 1'b0, 1'b1, 1'b0}},
    '{ROW_CFG, REG_BPS_CODE, 16'(BPS_4), '0},
    '{ROW_CFG, REG_WIDTH, 16'd3, '0},
    '{ROW_SAMPLE, '0, 16'hF0, '0},
    '{ROW_SAMPLE_KNOWN, '0, 16'h0F, '{8'hF0, 1'b0, 1'b1, 1'b0}},
    '{ROW_SAMPLE_KNOWN, '0, 16'hAB, '{8'hA0, 1'b0, 1'b1, 1'b0}},
    '{ROW_CFG, REG_BPS_CODE, 16'(BPS_16), '0},
    '{ROW_CFG, REG_WIDTH, 16'd1, '0},
    '{ROW_CFG, REG_LITTLE_END, 16'd0, '0},
    '{ROW_SAMPLE, '0, 16'h12, '0},
    '{ROW_SAMPLE, '0, 16'h34, '0},
    '{ROW_CFG, REG_LITTLE_END, 16'd1, '0},
    '{ROW_SAMPLE, '0, 16'hAB, '0},
    '{ROW_SAMPLE, '0, 16'hCD, '0},
    '{ROW_CFG, REG_BPS_CODE, 16'd7, '0},
    '{ROW_CFG, REG_SPP, 16'd3, '0},
    '{ROW_CFG, REG_WIDTH, 16'd1, '0},
    '{ROW_SAMPLE_KNOWN, '0, 16'h11, '{8'h11, 1'b0, 1'b1, 1'b0}},
    '{ROW_SAMPLE_KNOWN, '0, 16'h22, '{8'h22, 1'b0, 1'b1, 1'b0}},
    '{ROW_SAMPLE_KNOWN, '0, 16'h33, '{8'h33, 1'b0, 1'b1, 1'b0}},
    '{ROW_CFG, REG_BPS_CODE, 16'(BPS_2), '0},
    '{ROW_CFG, REG_WIDTH, 16'hFFFF, '0},
    '{ROW_SAMPLE_KNOWN, '0, 16'hFF, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{ROW_SAMPLE, '0, 16'h00, '0},
    '{ROW_SAMPLE, '0, 16'hFF, '0},
    '{ROW_CFG, REG_BPS_CODE, 16'(BPS_4), '0},
    '{ROW_SAMPLE_KNOWN, '0, 16'h9C, '{8'hCC, 1'b0, 1'b1, 1'b0}},
    '{ROW_CFG, REG_WIDTH, 16'd0, '0},
    '{ROW_SAMPLE_KNOWN, '0, 16'h5E, '{8'h95, 1'b0, 1'b1, 1'b0}}
  };

  initial begin : stimulus
    logic busy;
    int   random_sent;
    busy = 1'b0;
    random_sent = 0;
    reset_packer();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (busy) wait_idle();
        busy = 1'b0;
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].value[7:0], directed_rows[i].kind == ROW_SAMPLE_KNOWN,
                    directed_rows[i].known);
        busy = 1'b1;
      end
    end

    while (random_sent < RANDOM_ITEMS) random_phase(random_sent);

    // Finish the image on the next sample, then show that later samples are dropped.
    wait_idle();
    write_reg(REG_BPS_CODE, 16'(BPS_8));
    write_reg(REG_SPP, 16'd1);
    write_reg(REG_WIDTH, 16'd1);
    write_reg(REG_HEIGHT, 16'd1);
    write_reg(REG_HEIGHT, 16'd0);
    send_sample(8'hC3, 1'b0, '0);
    repeat (3) send_sample(8'($urandom_range(0, 255)), 1'b0, '0);
    wait_idle();
    repeat (20) @(negedge clk);

    if (byte_errors == 0 && expected_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
